// ===== src/psd_pkg.sv =====
package psd_pkg;

   localparam logic [1:0] SQRT_TRIAL_LSB = 2'b01;

   function automatic logic stage_ready(logic stage_valid, logic next_ready);
      return !stage_valid || next_ready;
   endfunction

endpackage

// ===== src/point_segment_distance_core.sv =====
// Point to segment distance, signed Q12.4 in, unsigned Q13.4 out.
// Input channel req_*: query point and the two segment endpoints, one
// transaction per query. Result channel rsp_*: rsp_distance, the floor of
// the Euclidean distance from the point to the nearest point on the segment.
// Every accepted transaction yields exactly one result, in order.
// Throughput: one transaction per cycle while the receiver keeps rsp_ready
// high. From acceptance to rsp_valid a transaction passes three front
// stages, one stage per quotient bit of the projection divider, four stages
// for nearest point and squared error, and one stage per root bit of the
// square root.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up and a stalled receiver fills
// the pipeline before req_ready drops.
// Synchronous active-high reset empties the pipeline; no result is pending
// afterwards and there is no other state.
module point_segment_distance_core
   import psd_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 16,
   parameter int unsigned PARAM_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_WIDTH:0]          rsp_distance
);

   localparam int unsigned C     = COORD_WIDTH;
   localparam int unsigned F     = PARAM_FRAC_BITS;
   localparam int unsigned D_W   = C + 1;
   localparam int unsigned P_W   = 2 * C + 2;
   localparam int unsigned N_W   = 2 * C + 1;
   localparam int unsigned T_W   = F + 1;
   localparam int unsigned M_W   = T_W + C;
   localparam int unsigned SIDE_W = 4 * C + 2 * D_W + 1;

   // stage 1: differences
   logic                  v1_ff;
   logic                  r1;
   logic signed [C-1:0]   s1_px_ff, s1_py_ff, s1_sx_ff, s1_sy_ff;
   logic signed [D_W-1:0] s1_dx_ff, s1_dy_ff, s1_wx_ff, s1_wy_ff;

   // stage 2: products
   logic                  v2_ff;
   logic                  r2;
   logic signed [C-1:0]   s2_px_ff, s2_py_ff, s2_sx_ff, s2_sy_ff;
   logic signed [D_W-1:0] s2_dx_ff, s2_dy_ff;
   logic signed [P_W-1:0] s2_dxx_ff, s2_dyy_ff, s2_dwx_ff, s2_dwy_ff;

   // stage 3: sums and clamp
   logic                  v3_ff;
   logic                  r3;
   logic signed [P_W-1:0] len2_in, dot_in;
   logic                  zero_in, one_in;
   logic [N_W-1:0]        s3_rem_ff, s3_den_ff;
   logic [SIDE_W-1:0]     s3_side_ff;

   logic                  div_in_ready;
   logic                  div_out_valid;
   logic [F-1:0]          div_quo;
   logic [SIDE_W-1:0]     div_side;

   logic signed [C-1:0]   d_px, d_py, d_sx, d_sy;
   logic signed [D_W-1:0] d_dx, d_dy;
   logic                  d_one;
   logic [T_W-1:0]        t_in;
   logic [D_W-1:0]        dx_abs, dy_abs;

   // stage 4: t times segment magnitude
   logic                  v4_ff;
   logic                  r4;
   logic signed [C-1:0]   s4_px_ff, s4_py_ff, s4_sx_ff, s4_sy_ff;
   logic                  s4_xneg_ff, s4_yneg_ff;
   logic [M_W-1:0]        s4_tx_ff, s4_ty_ff;

   // stage 5: nearest point and error magnitude
   logic                  v5_ff;
   logic                  r5;
   logic signed [C+1:0]   qx_in, qy_in, ex_in, ey_in;
   logic [C+1:0]          ax_full, ay_full;
   logic [C-1:0]          s5_ax_ff, s5_ay_ff;

   // stage 6: squares
   logic                  v6_ff;
   logic                  r6;
   logic [2*C-1:0]        s6_xx_ff, s6_yy_ff;

   // stage 7: squared error
   logic                  v7_ff;
   logic                  r7;
   logic [N_W-1:0]        s7_sum_ff;

   logic                  sq_in_ready;

   assign r7 = stage_ready(v7_ff, sq_in_ready);
   assign r6 = stage_ready(v6_ff, r7);
   assign r5 = stage_ready(v5_ff, r6);
   assign r4 = stage_ready(v4_ff, r5);
   assign r3 = stage_ready(v3_ff, div_in_ready);
   assign r2 = stage_ready(v2_ff, r3);
   assign r1 = stage_ready(v1_ff, r2);
   assign req_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= div_out_valid;
         if (r5) v5_ff <= v4_ff;
         if (r6) v6_ff <= v5_ff;
         if (r7) v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         s1_px_ff <= req_point_x;
         s1_py_ff <= req_point_y;
         s1_sx_ff <= req_start_x;
         s1_sy_ff <= req_start_y;
         s1_dx_ff <= D_W'(req_end_x) - D_W'(req_start_x);
         s1_dy_ff <= D_W'(req_end_y) - D_W'(req_start_y);
         s1_wx_ff <= D_W'(req_point_x) - D_W'(req_start_x);
         s1_wy_ff <= D_W'(req_point_y) - D_W'(req_start_y);
      end
   end

   always_ff @(posedge clock) begin
      if (r2) begin
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_sx_ff  <= s1_sx_ff;
         s2_sy_ff  <= s1_sy_ff;
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_dxx_ff <= P_W'(s1_dx_ff) * P_W'(s1_dx_ff);
         s2_dyy_ff <= P_W'(s1_dy_ff) * P_W'(s1_dy_ff);
         s2_dwx_ff <= P_W'(s1_wx_ff) * P_W'(s1_dx_ff);
         s2_dwy_ff <= P_W'(s1_wy_ff) * P_W'(s1_dy_ff);
      end
   end

   always_comb begin
      len2_in = s2_dxx_ff + s2_dyy_ff;
      dot_in  = s2_dwx_ff + s2_dwy_ff;
      zero_in = (len2_in == '0) || (dot_in <= 0);
      one_in  = !zero_in && (dot_in >= len2_in);
   end

   always_ff @(posedge clock) begin
      if (r3) begin
         s3_rem_ff  <= (zero_in || one_in) ? '0 : dot_in[N_W-1:0];
         s3_den_ff  <= (zero_in || one_in) ? N_W'(1) : len2_in[N_W-1:0];
         s3_side_ff <= {s2_px_ff, s2_py_ff, s2_sx_ff, s2_sy_ff,
                        s2_dx_ff, s2_dy_ff, one_in};
      end
   end

   psd_div #(
      .NUM_WIDTH (N_W),
      .QUO_BITS  (F),
      .SIDE_WIDTH(SIDE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3_ff),
      .in_ready (div_in_ready),
      .in_rem   (s3_rem_ff),
      .in_den   (s3_den_ff),
      .in_side  (s3_side_ff),
      .out_valid(div_out_valid),
      .out_ready(r4),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   always_comb begin
      {d_px, d_py, d_sx, d_sy, d_dx, d_dy, d_one} = div_side;
      t_in   = d_one ? {1'b1, {F{1'b0}}} : {1'b0, div_quo};
      dx_abs = d_dx[D_W-1] ? -d_dx : d_dx;
      dy_abs = d_dy[D_W-1] ? -d_dy : d_dy;
   end

   always_ff @(posedge clock) begin
      if (r4) begin
         s4_px_ff   <= d_px;
         s4_py_ff   <= d_py;
         s4_sx_ff   <= d_sx;
         s4_sy_ff   <= d_sy;
         s4_xneg_ff <= d_dx[D_W-1];
         s4_yneg_ff <= d_dy[D_W-1];
         s4_tx_ff   <= M_W'(t_in) * M_W'(dx_abs[C-1:0]);
         s4_ty_ff   <= M_W'(t_in) * M_W'(dy_abs[C-1:0]);
      end
   end

   always_comb begin
      qx_in = s4_xneg_ff ? (C+2)'(s4_sx_ff) - $signed((C+2)'(s4_tx_ff[M_W-1:F]))
                         : (C+2)'(s4_sx_ff) + $signed((C+2)'(s4_tx_ff[M_W-1:F]));
      qy_in = s4_yneg_ff ? (C+2)'(s4_sy_ff) - $signed((C+2)'(s4_ty_ff[M_W-1:F]))
                         : (C+2)'(s4_sy_ff) + $signed((C+2)'(s4_ty_ff[M_W-1:F]));
      ex_in   = (C+2)'(s4_px_ff) - qx_in;
      ey_in   = (C+2)'(s4_py_ff) - qy_in;
      ax_full = ex_in[C+1] ? -ex_in : ex_in;
      ay_full = ey_in[C+1] ? -ey_in : ey_in;
   end

   always_ff @(posedge clock) begin
      if (r5) begin
         s5_ax_ff <= ax_full[C-1:0];
         s5_ay_ff <= ay_full[C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (r6) begin
         s6_xx_ff <= (2*C)'(s5_ax_ff) * (2*C)'(s5_ax_ff);
         s6_yy_ff <= (2*C)'(s5_ay_ff) * (2*C)'(s5_ay_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (r7) begin
         s7_sum_ff <= N_W'(s6_xx_ff) + N_W'(s6_yy_ff);
      end
   end

   psd_sqrt #(
      .ROOT_WIDTH(D_W)
   ) u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v7_ff),
      .in_ready   (sq_in_ready),
      .in_radicand({1'b0, s7_sum_ff}),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_root   (rsp_distance)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while pipeline has room");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> s3_rem_ff < s3_den_ff)
      else $error("divider numerator not below denominator");

endmodule

// ===== src/psd_div.sv =====
module psd_div
   import psd_pkg::*;
#(
   parameter int unsigned NUM_WIDTH = 33,
   parameter int unsigned QUO_BITS = 16,
   parameter int unsigned SIDE_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [NUM_WIDTH-1:0]  in_rem,
   input  logic [NUM_WIDTH-1:0]  in_den,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [QUO_BITS-1:0]   out_quo,
   output logic [SIDE_WIDTH-1:0] out_side
);

   logic [QUO_BITS-1:0]   valid_ff;
   logic [QUO_BITS-1:0]   rdy;
   logic [NUM_WIDTH-1:0]  rem_ff  [QUO_BITS];
   logic [NUM_WIDTH-1:0]  den_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]   quo_ff  [QUO_BITS];
   logic [SIDE_WIDTH-1:0] side_ff [QUO_BITS];

   always_comb begin
      rdy[QUO_BITS-1] = stage_ready(valid_ff[QUO_BITS-1], out_ready);
      for (int i = QUO_BITS - 2; i >= 0; i--) begin
         rdy[i] = stage_ready(valid_ff[i], rdy[i+1]);
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_quo   = quo_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_step
      logic [NUM_WIDTH-1:0]  prev_rem;
      logic [NUM_WIDTH-1:0]  prev_den;
      logic [QUO_BITS-1:0]   prev_quo;
      logic [SIDE_WIDTH-1:0] prev_side;
      logic                  prev_valid;
      logic [NUM_WIDTH:0]    shifted;
      logic                  fits;
      logic [NUM_WIDTH:0]    diff;
      logic [NUM_WIDTH-1:0]  rem_in;
      logic [QUO_BITS-1:0]   quo_in;

      if (g == 0) begin : g_first
         assign prev_rem   = in_rem;
         assign prev_den   = in_den;
         assign prev_quo   = '0;
         assign prev_side  = in_side;
         assign prev_valid = in_valid;
      end else begin : g_next
         assign prev_rem   = rem_ff[g-1];
         assign prev_den   = den_ff[g-1];
         assign prev_quo   = quo_ff[g-1];
         assign prev_side  = side_ff[g-1];
         assign prev_valid = valid_ff[g-1];
      end

      always_comb begin
         shifted = {prev_rem, 1'b0};
         fits    = shifted >= {1'b0, prev_den};
         diff    = shifted - {1'b0, prev_den};
         rem_in  = fits ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
         quo_in  = {prev_quo[QUO_BITS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            valid_ff[g] <= prev_valid;
         end
         if (rdy[g]) begin
            rem_ff[g]  <= rem_in;
            den_ff[g]  <= prev_den;
            quo_ff[g]  <= quo_in;
            side_ff[g] <= prev_side;
         end
      end
   end

endmodule

// ===== src/psd_sqrt.sv =====
module psd_sqrt
   import psd_pkg::*;
#(
   parameter int unsigned ROOT_WIDTH = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2*ROOT_WIDTH-1:0] in_radicand,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [ROOT_WIDTH-1:0]   out_root
);

   localparam int unsigned RAD_W = 2 * ROOT_WIDTH;
   localparam int unsigned REM_W = ROOT_WIDTH + 3;

   logic [ROOT_WIDTH-1:0] valid_ff;
   logic [ROOT_WIDTH-1:0] rdy;
   logic [RAD_W-1:0]      rad_ff  [ROOT_WIDTH];
   logic [REM_W-1:0]      rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];

   always_comb begin
      rdy[ROOT_WIDTH-1] = stage_ready(valid_ff[ROOT_WIDTH-1], out_ready);
      for (int i = ROOT_WIDTH - 2; i >= 0; i--) begin
         rdy[i] = stage_ready(valid_ff[i], rdy[i+1]);
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];

   for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_digit
      logic [RAD_W-1:0]      prev_rad;
      logic [REM_W-1:0]      prev_rem;
      logic [ROOT_WIDTH-1:0] prev_root;
      logic                  prev_valid;
      logic [REM_W-1:0]      rem_sh;
      logic [REM_W-1:0]      trial;
      logic                  fits;
      logic [REM_W-1:0]      rem_in;
      logic [ROOT_WIDTH-1:0] root_in;
      logic [RAD_W-1:0]      rad_in;

      if (g == 0) begin : g_first
         assign prev_rad   = in_radicand;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_valid = in_valid;
      end else begin : g_next
         assign prev_rad   = rad_ff[g-1];
         assign prev_rem   = rem_ff[g-1];
         assign prev_root  = root_ff[g-1];
         assign prev_valid = valid_ff[g-1];
      end

      always_comb begin
         rem_sh  = {prev_rem[REM_W-3:0], prev_rad[RAD_W-1:RAD_W-2]};
         trial   = {prev_root, SQRT_TRIAL_LSB};
         fits    = rem_sh >= trial;
         rem_in  = fits ? rem_sh - trial : rem_sh;
         root_in = {prev_root[ROOT_WIDTH-2:0], fits};
         rad_in  = {prev_rad[RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            valid_ff[g] <= prev_valid;
         end
         if (rdy[g]) begin
            rad_ff[g]  <= rad_in;
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
         end
      end
   end

endmodule
